@@ src/bsc_pkg.sv @@
// Shared types, constants and opcodes of the banker's safety checker.
// No dependencies.
package bsc_pkg;
  localparam int MAX_PROCS  = 16;
  localparam int MAX_RES    = 8;
  localparam int COUNT_BITS = 16;
  localparam int PW = $clog2(MAX_PROCS);
  localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW = $clog2(DEPTH);
  localparam int WW = COUNT_BITS + PW + 1;

  localparam logic [1:0] OP_LOAD_CELL  = 2'd0;
  localparam logic [1:0] OP_LOAD_AVAIL = 2'd1;
  localparam logic [1:0] OP_REQUEST    = 2'd2;
  localparam logic [1:0] OP_CHECK      = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_SEQ      = 3'd2;
  localparam logic [2:0] ST_UNSAFE   = 3'd3;
  localparam logic [2:0] ST_CLAIM    = 3'd4;
  localparam logic [2:0] ST_NOAVAIL  = 3'd5;

  localparam logic [0:0] CFG_NPROC = 1'd0;
  localparam logic [0:0] CFG_NRES  = 1'd1;

  typedef struct packed {
    logic [2:0]    status;
    logic [3:0]    seq_process;
    logic [3:0]    seq_position;
    logic          last_result;
  } result_t;
endpackage

@@ src/bsc_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module bsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ src/bankers_safety_checker.sv @@
// Top level of the banker's safety checker: sequencer, vectors, shared compare/add unit.
// Depends on bsc_pkg and bsc_ram (allocation and need tables).
//
//  channel | direction | handshake
//  in_*    | input     | in_valid / in_ready
//  out_*   | output    | out_valid / out_ready
//  cfg_*   | input     | cfg_we, no wait
//
// A load is accepted, then its status beat is shown; in_ready returns the cycle after
// that beat is taken. A safety check reads and compares need cells, reads and adds
// allocation cells and skips finished processes; a request adds claim and available
// tests before it and, when safe, a commit of both tables after it. Each result beat
// is held until out_ready takes it. Reset is synchronous; the table clear sweep after
// reset writes every cell while in_ready stays low. The output stalls the sequencer,
// never the reverse.
module bankers_safety_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [4:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [3:0]                       in_process_index,
  input  logic [2:0]                       in_resource_index,
  input  logic [15:0]                      in_max_claim,
  input  logic [15:0]                      in_amount,
  input  logic                             in_last_element,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [3:0]                       out_seq_process,
  output logic [3:0]                       out_seq_position,
  output logic                             out_last_result
);
  import bsc_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_REQRD   = 4'd2;
  localparam logic [3:0] S_REQCMP  = 4'd3;
  localparam logic [3:0] S_INIT    = 4'd4;
  localparam logic [3:0] S_FITRD   = 4'd5;
  localparam logic [3:0] S_FITCMP  = 4'd6;
  localparam logic [3:0] S_ADDRD   = 4'd7;
  localparam logic [3:0] S_ADDCMP  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;
  localparam logic [3:0] S_COMMIT  = 4'd11;
  localparam logic [3:0] S_CMTWR   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [AW-1:0] clr_r;

  logic [4:0] nproc_r;
  logic [3:0] nres_r;
  logic [PW:0] n_use;
  logic [RW:0] r_use;

  logic [COUNT_BITS-1:0] avail_r [MAX_RES];
  logic [COUNT_BITS-1:0] stage_r [MAX_RES];
  logic [WW-1:0]         work_r  [MAX_RES];
  logic [MAX_PROCS-1:0]  fin_r;
  logic [PW-1:0]         seq_r   [MAX_PROCS];

  logic [PW-1:0] p_r, i_r, cnt_r, emit_r;
  logic [RW-1:0] j_r;
  logic          tent_r, took_r, mode_r, safe_r;
  result_t       res_r;
  logic          ov_r;

  // table ports
  logic                  a_we, n_we;
  logic [AW-1:0]         t_addr;
  logic [COUNT_BITS-1:0] a_wd, n_wd, a_rd, n_rd;
  logic [PW-1:0]         t_p;
  logic [RW-1:0]         t_j;

  // shared unit operands
  logic [COUNT_BITS-1:0] nd_eff;
  logic [WW-1:0]         a_eff;
  logic                  mine;

  always_comb begin
    n_use = (nproc_r == 5'd0) ? (PW+1)'(1) :
            (nproc_r > 5'(MAX_PROCS)) ? (PW+1)'(MAX_PROCS) : (PW+1)'(nproc_r);
    r_use = (nres_r == 4'd0) ? (RW+1)'(1) :
            (nres_r > 4'(MAX_RES)) ? (RW+1)'(MAX_RES) : (RW+1)'(nres_r);
  end

  bsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_alloc (
    .clk(clk), .we(a_we), .addr(t_addr), .wdata(a_wd), .rdata(a_rd));
  bsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_need (
    .clk(clk), .we(n_we), .addr(t_addr), .wdata(n_wd), .rdata(n_rd));

  assign mine   = tent_r && (i_r == p_r);
  assign nd_eff = mine ? n_rd - stage_r[j_r] : n_rd;
  assign a_eff  = WW'(a_rd) + (mine ? WW'(stage_r[j_r]) : '0);

  always_comb begin
    t_p  = i_r;
    t_j  = j_r;
    a_we = 1'b0;
    n_we = 1'b0;
    a_wd = in_amount;
    n_wd = in_max_claim - in_amount;
    if (state_r == S_CLEAR) begin
      a_we = 1'b1;
      n_we = 1'b1;
      a_wd = '0;
      n_wd = '0;
    end else if (state_r == S_IDLE) begin
      t_p = in_process_index[PW-1:0];
      t_j = in_resource_index[RW-1:0];
      a_we = in_valid && in_ready && in_opcode == OP_LOAD_CELL &&
             (PW+1)'(in_process_index) < n_use && (RW+1)'(in_resource_index) < r_use &&
             in_amount <= in_max_claim;
      n_we = a_we;
    end else if (state_r == S_CMTWR) begin
      a_we = 1'b1;
      n_we = 1'b1;
      a_wd = a_rd + stage_r[j_r];
      n_wd = n_rd - stage_r[j_r];
    end
  end
  assign t_addr = (state_r == S_CLEAR) ? clr_r : AW'({t_p, t_j});

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = res_r.status;
  assign out_seq_process = res_r.seq_process;
  assign out_seq_position = res_r.seq_position;
  assign out_last_result = res_r.last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nproc_r <= 5'd16;
      nres_r  <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NPROC) nproc_r <= cfg_data;
      else nres_r <= cfg_data[3:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  state_nxt = (clr_r == AW'(DEPTH-1)) ? S_IDLE : S_CLEAR;
      default:  state_nxt = state_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      fin_r   <= '0;
      for (int k = 0; k < MAX_RES; k++) begin
        avail_r[k] <= '0;
        stage_r[k] <= '0;
      end
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          state_r <= state_nxt;
        end
        S_IDLE: if (in_valid && !ov_r) begin
          res_r.seq_process  <= 4'd0;
          res_r.seq_position <= 4'd0;
          res_r.last_result  <= 1'b1;
          p_r  <= in_process_index[PW-1:0];
          unique case (in_opcode)
            OP_LOAD_CELL: begin
              ov_r <= 1'b1;
              res_r.status <= a_we ? ST_OK : ST_REJECT;
            end
            OP_LOAD_AVAIL: begin
              ov_r <= 1'b1;
              if ((RW+1)'(in_resource_index) < r_use) begin
                avail_r[in_resource_index[RW-1:0]] <= in_amount;
                res_r.status <= ST_OK;
              end else res_r.status <= ST_REJECT;
            end
            OP_REQUEST: begin
              if (in_last_element && (PW+1)'(in_process_index) >= n_use) begin
                // no claim for a process not in use: drop the staged vector
                res_r.status <= ST_CLAIM;
                ov_r <= 1'b1;
                for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
              end else begin
                if ((RW+1)'(in_resource_index) < r_use)
                  stage_r[in_resource_index[RW-1:0]] <= in_amount;
                if (!in_last_element) begin
                  res_r.status <= ST_OK;
                  ov_r <= 1'b1;
                end else begin
                  i_r <= in_process_index[PW-1:0];
                  j_r <= '0;
                  mode_r <= 1'b0;
                  state_r <= S_REQRD;
                end
              end
            end
            default: begin
              tent_r <= 1'b0;
              state_r <= S_INIT;
            end
          endcase
        end
        S_REQRD: state_r <= S_REQCMP;
        // mode 0: claim test over need; mode 1: availability test
        S_REQCMP: begin
          if (!mode_r && stage_r[j_r] > n_rd) begin
            res_r.status <= ST_CLAIM;
            ov_r <= 1'b1;
            for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
            state_r <= S_IDLE;
          end else if (mode_r && stage_r[j_r] > avail_r[j_r]) begin
            res_r.status <= ST_NOAVAIL;
            ov_r <= 1'b1;
            for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
            state_r <= S_IDLE;
          end else if ((RW+1)'(j_r) + (RW+1)'(1) < r_use) begin
            j_r <= j_r + RW'(1);
            state_r <= S_REQRD;
          end else if (!mode_r) begin
            j_r <= '0;
            mode_r <= 1'b1;
            state_r <= S_REQRD;
          end else begin
            tent_r <= 1'b1;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          for (int k = 0; k < MAX_RES; k++)
            work_r[k] <= WW'(avail_r[k]) - (tent_r ? WW'(stage_r[k]) : '0);
          fin_r  <= '0;
          cnt_r  <= '0;
          i_r    <= '0;
          j_r    <= '0;
          took_r <= 1'b0;
          state_r <= S_FITRD;
        end
        S_FITRD: begin
          if (fin_r[i_r]) begin
            if ((PW+1)'(i_r) + (PW+1)'(1) < n_use) i_r <= i_r + PW'(1);
            else begin
              i_r <= '0;
              took_r <= 1'b0;
              if (!took_r) begin
                safe_r <= 1'b0;
                state_r <= S_EMIT;
              end
            end
          end else state_r <= S_FITCMP;
        end
        S_FITCMP: begin
          if (WW'(nd_eff) > work_r[j_r]) begin
            j_r <= '0;
            if ((PW+1)'(i_r) + (PW+1)'(1) < n_use) begin
              i_r <= i_r + PW'(1);
              state_r <= S_FITRD;
            end else begin
              i_r <= '0;
              took_r <= 1'b0;
              if (!took_r) begin
                safe_r <= 1'b0;
                state_r <= S_EMIT;
              end else state_r <= S_FITRD;
            end
          end else if ((RW+1)'(j_r) + (RW+1)'(1) < r_use) begin
            j_r <= j_r + RW'(1);
            state_r <= S_FITRD;
          end else begin
            j_r <= '0;
            state_r <= S_ADDRD;
          end
        end
        S_ADDRD: state_r <= S_ADDCMP;
        S_ADDCMP: begin
          work_r[j_r] <= work_r[j_r] + a_eff;
          if ((RW+1)'(j_r) + (RW+1)'(1) < r_use) begin
            j_r <= j_r + RW'(1);
            state_r <= S_ADDRD;
          end else begin
            j_r <= '0;
            fin_r[i_r] <= 1'b1;
            seq_r[cnt_r] <= i_r;
            // a take on the last process closes the pass: start the next one clean
            took_r <= (PW+1)'(i_r) + (PW+1)'(1) < n_use;
            if ((PW+1)'(cnt_r) + (PW+1)'(1) >= n_use) begin
              safe_r <= 1'b1;
              emit_r <= '0;
              state_r <= S_EMIT;
            end else begin
              cnt_r <= cnt_r + PW'(1);
              if ((PW+1)'(i_r) + (PW+1)'(1) < n_use) i_r <= i_r + PW'(1);
              else i_r <= '0;
              state_r <= S_FITRD;
            end
          end
        end
        S_EMIT: if (!ov_r) begin
          ov_r <= 1'b1;
          if (!safe_r) begin
            res_r <= '{status: ST_UNSAFE, seq_process: 4'd0, seq_position: 4'd0,
                       last_result: 1'b1};
            for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
            state_r <= S_IDLE;
          end else begin
            res_r <= '{status: ST_SEQ, seq_process: 4'(seq_r[emit_r]),
                       seq_position: 4'(emit_r),
                       last_result: (PW+1)'(emit_r) + (PW+1)'(1) == n_use};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if ((PW+1)'(emit_r) + (PW+1)'(1) < n_use) begin
            emit_r <= emit_r + PW'(1);
            state_r <= S_EMIT;
          end else if (tent_r) begin
            i_r <= p_r;
            j_r <= '0;
            state_r <= S_COMMIT;
          end else begin
            for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
            state_r <= S_IDLE;
          end
        end
        // read-modify-write one cell of both tables per resource
        S_COMMIT: state_r <= S_CMTWR;
        S_CMTWR: begin
          avail_r[j_r] <= avail_r[j_r] - stage_r[j_r];
          if ((RW+1)'(j_r) + (RW+1)'(1) < r_use) begin
            j_r <= j_r + RW'(1);
            state_r <= S_COMMIT;
          end else begin
            for (int k = 0; k < MAX_RES; k++) stage_r[k] <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_seq_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SEQ |-> (PW+1)'(out_seq_position) < n_use)
    else $error("sequence position out of range");
`endif
endmodule
